// ===== hdl/sha256_stream_hasher_unit_macros.svh =====
// Assertion macros used by the hasher's top-level file.
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SHA_CHECK(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold at the same edge.
`define SHA_CHECK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/sha_pkg.sv =====
package sha_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef struct packed {
        logic [31:0] word;
        logic        blk_end;
        logic        msg_end;
    } fifo_entry_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_START  = 6'd55;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST  = 2'd3;
    localparam logic [7:0] NUM_REGS   = 8'd4;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] v);
        big_s0 = ror(v, 2) ^ ror(v, 13) ^ ror(v, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] v);
        big_s1 = ror(v, 6) ^ ror(v, 11) ^ ror(v, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] v);
        small_s0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] v);
        small_s1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
    endfunction

endpackage

// ===== hdl/sha_fifo.sv =====
module sha_fifo
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fifo_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        empty,
    output fifo_entry_t pop_data
);

    fifo_entry_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]        count_reg, count_next;

    assign full     = (count_reg == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/sha_front.sv =====
module sha_front
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        final_item,
    input  logic        q_full,
    output logic        q_push,
    output fifo_entry_t q_data
);

    typedef enum logic [2:0] {
        ST_ACCEPT = 3'b001,
        ST_PAD    = 3'b010,
        ST_LEN    = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [5:0]   fill_reg;
    logic [23:0]  acc_reg;
    logic [63:0]  count_reg;
    logic [63:0]  len_reg, len_next;
    logic         first_reg;
    logic         byte_valid;
    logic [7:0]   byte_val;
    logic         accept;
    logic [63:0]  count_final;

    assign in_ready    = (state_reg == ST_ACCEPT) && !q_full;
    assign accept      = in_valid && in_ready;
    assign count_final = count_reg + {63'd0, byte_present};

    always_comb
    begin
        byte_valid = 1'b0;
        byte_val   = data_byte;
        state_next = state_reg;
        len_next   = len_reg;
        case (state_reg)
            ST_ACCEPT:
            begin
                byte_valid = accept && byte_present;
                if (accept && final_item)
                begin
                    state_next = ST_PAD;
                    len_next   = count_final << 3;
                end
            end
            ST_PAD:
            begin
                byte_valid = !q_full;
                byte_val   = first_reg ? PAD_BYTE : 8'd0;
                if (!q_full && fill_reg == LEN_START)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                byte_valid = !q_full;
                byte_val   = len_reg[63:56];
                if (!q_full)
                begin
                    len_next = len_reg << 8;
                    if (fill_reg == BLOCK_LAST)
                    begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    assign q_push         = byte_valid && (fill_reg[1:0] == WORD_LAST);
    assign q_data.word    = {acc_reg, byte_val};
    assign q_data.blk_end = (fill_reg == BLOCK_LAST);
    assign q_data.msg_end = (fill_reg == BLOCK_LAST) && (state_reg == ST_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            fill_reg  <= '0;
            count_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (byte_valid)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (accept)
            begin
                count_reg <= final_item ? 64'd0 : count_final;
            end
            if (state_reg == ST_ACCEPT)
            begin
                first_reg <= 1'b1;
            end
            else if (state_reg == ST_PAD && !q_full)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (byte_valid)
        begin
            acc_reg <= {acc_reg[15:0], byte_val};
        end
    end

endmodule

// ===== hdl/sha_core.sv =====
module sha_core
    import sha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  fifo_entry_t  q_data,
    output logic         q_pop,
    input  logic [255:0] expected,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  digest_word,
    output logic [2:0]   word_number,
    output logic         last_word,
    output logic         digest_matches
);

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_ROUND  = 5'b00010,
        ST_FINISH = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_EMIT   = 5'b10000
    } core_state_t;

    core_state_t state_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] vars_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic [2:0]  idx_reg;
    logic        msg_end_reg;
    logic        match_reg;
    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_num_reg;
    logic        out_last_reg;
    logic        out_match_reg;
    logic [31:0] t1, t2, w_new, ch, maj;
    logic        emit_load;

    assign q_pop     = (state_reg == ST_LOAD) && !q_empty;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj   = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]);
        t1    = vars_reg[7] + big_s1(vars_reg[4]) + ch + ROUND_K[rnd_reg] + w_reg[0];
        t2    = big_s0(vars_reg[0]) + maj;
        w_new = small_s1(w_reg[14]) + w_reg[9] + small_s0(w_reg[1]) + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else
        begin
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (q_pop && q_data.blk_end)
                    begin
                        state_reg <= ST_ROUND;
                        rnd_reg   <= '0;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + vars_reg[i];
                    end
                    state_reg <= msg_end_reg ? ST_CHECK : ST_LOAD;
                end
                ST_CHECK:
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7)
                        begin
                            // The next message starts from the initial hash.
                            for (int i = 0; i < 8; i++)
                            begin
                                chain_reg[i] <= IV[i];
                            end
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= q_data.word;
            if (q_data.blk_end)
            begin
                msg_end_reg <= q_data.msg_end;
                for (int i = 0; i < 8; i++)
                begin
                    vars_reg[i] <= chain_reg[i];
                end
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            // The schedule window slides by one word each round.
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            for (int i = 1; i < 8; i++)
            begin
                vars_reg[i] <= vars_reg[i-1];
            end
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_CHECK)
        begin
            match_reg <= (expected == {chain_reg[0], chain_reg[1], chain_reg[2],
                chain_reg[3], chain_reg[4], chain_reg[5], chain_reg[6], chain_reg[7]});
        end
        if (emit_load)
        begin
            out_word_reg  <= chain_reg[idx_reg];
            out_num_reg   <= idx_reg;
            out_last_reg  <= (idx_reg == 3'd7);
            out_match_reg <= match_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign digest_word    = out_word_reg;
    assign word_number    = out_num_reg;
    assign last_word      = out_last_reg;
    assign digest_matches = out_match_reg;

endmodule

// ===== hdl/sha256_stream_hasher_unit.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    data_byte, byte_present, final_item
// out       output     out_valid / out_ready  digest_word, word_number, last_word,
//                                             digest_matches
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes one byte per cycle while in_ready is high and packs words into a
// four-entry queue; the core runs 64 rounds and a chaining update per 64-byte block.
// A final item adds padding bytes, one per cycle unless the queue is full, to the block
// end (one more block when under nine bytes are left), rounds, a check and 8 transfers.
// Reset is asynchronous and clears all control state; out_ready low stalls
// only the core, and the front keeps going until the queue is full.
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        final_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word,
    output logic        digest_matches,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    `include "sha256_stream_hasher_unit_macros.svh"

    logic [63:0] expected_reg [4];
    logic        q_push, q_full;
    fifo_entry_t push_data, pop_data;
    logic        q_pop, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                expected_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        begin
            expected_reg[cfg_index[1:0]] <= cfg_data;
        end
    end

    sha_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .final_item   (final_item),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (push_data)
    );

    sha_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    sha_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .q_pop          (q_pop),
        .expected       ({expected_reg[0], expected_reg[1], expected_reg[2],
                          expected_reg[3]}),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_number    (word_number),
        .last_word      (last_word),
        .digest_matches (digest_matches)
    );

    `SHA_CHECK(a_no_overflow, !(q_push && q_full))
    `SHA_CHECK_IMPLY(a_last_is_seven, out_valid, last_word == (word_number == 3'd7))
    `SHA_CHECK_IMPLY(a_digest_starts_at_zero, $rose(out_valid), word_number == 3'd0)

endmodule
